### sv/meter_chip_uart_command_engine_unit_macros.svh
// Assertion macros for the UART command engine checker.
// Depends on nothing; included by the checker file.
`ifndef METER_CHIP_UART_COMMAND_ENGINE_UNIT_MACROS_SVH
`define METER_CHIP_UART_COMMAND_ENGINE_UNIT_MACROS_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define MCUCE_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion on the engine's own clock and reset.
`define MCUCE_ASSERT(label, prop, msg) \
    `MCUCE_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

### sv/mcuce_pkg.sv
// Shared types, codes and constants of the UART command engine.
// Used by every module of the engine; depends on nothing.
`timescale 1ns / 1ps

package mcuce_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int MAX_WORDS       = 16;

    localparam logic [1:0] CODE_READ      = 2'd1;
    localparam logic [1:0] CODE_WRITE     = 2'd2;
    localparam logic [1:0] CODE_BROADCAST = 2'd0;

    localparam logic [2:0] FUNC_WRITE = 3'd0;
    localparam logic [2:0] FUNC_READ  = 3'd1;
    localparam logic [2:0] FUNC_BCAST = 3'd2;
    localparam logic [2:0] FUNC_RX    = 3'd3;
    localparam logic [2:0] FUNC_TICK  = 3'd4;

    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_WORD   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_SUM = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;
    localparam logic [1:0] ST_BUSY    = 2'd3;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_BCAST = 2'd2;

    localparam logic CFG_SLAVE_ADDR = 1'b0;
    localparam logic CFG_BYTE_TIME  = 1'b1;

    localparam logic [7:0]  FRAME_START  = 8'h7d;
    localparam logic [7:0]  SUM_BIAS     = 8'h33;
    localparam logic [6:0]  ADDR_MASK    = 7'h7f;
    localparam logic [14:0] TMO_ROUND    = 15'd10;
    localparam logic [15:0] DIV10_MUL    = 16'd52429;
    localparam int          DIV10_SHIFT  = 19;
    localparam logic [6:0]  MUL_WRITE    = 7'd9;
    localparam logic [6:0]  MUL_BCAST    = 7'd8;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_RX    = 2'd1,
        PH_BCAST = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ACT_FRAME4 = 2'd0,
        ACT_FRAME8 = 2'd1,
        ACT_WORD   = 2'd2,
        ACT_STATUS = 2'd3
    } t_act;

    typedef struct packed {
        t_act        act;
        logic [7:0]  cmd;
        logic [6:0]  addr;
        logic [31:0] data;
        logic [7:0]  sum;
        logic [1:0]  status;
    } t_desc;

    function automatic logic [7:0] fin_sum(input logic [7:0] s);
        fin_sum = (~s) + SUM_BIAS;
    endfunction

endpackage

### sv/mcuce_fifo.sv
// Small descriptor queue between the front and the back of the engine.
// Depends on mcuce_pkg for the descriptor type.
`timescale 1ns / 1ps

module mcuce_fifo #(
    parameter int DEPTH = mcuce_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mcuce_pkg::t_desc  i_data,
    output logic              o_full,
    input  logic              i_pop,
    output mcuce_pkg::t_desc  o_data,
    output logic              o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    mcuce_pkg::t_desc r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### sv/mcuce_front.sv
// Front of the engine: accepts items, keeps the protocol state and the timeout,
// and queues one result descriptor per item that has results. Uses mcuce_pkg.
`timescale 1ns / 1ps

module mcuce_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_index,
    input  logic [7:0]        i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [2:0]        i_func,
    input  logic [6:0]        i_reg_addr,
    input  logic [31:0]       i_write_data,
    input  logic [4:0]        i_word_count,
    input  logic [7:0]        i_rx_byte,
    output logic              o_push,
    output mcuce_pkg::t_desc  o_desc,
    input  logic              i_full
);

    logic [1:0]          r_slave_addr, n_slave_addr;
    logic [7:0]          r_byte_time, n_byte_time;
    mcuce_pkg::t_phase   r_phase, n_phase;
    logic [1:0]          r_pending_op, n_pending_op;
    logic [7:0]          r_expect_sum, n_expect_sum;
    logic [6:0]          r_rx_count, n_rx_count;
    logic [6:0]          r_rx_total, n_rx_total;
    logic [23:0]         r_word_shift, n_word_shift;
    logic [15:0]         r_timeout_left, n_timeout_left;
    logic                r_tmo_pend, n_tmo_pend;
    logic [14:0]         r_tmo_num, n_tmo_num;
    logic                r_tmo_plus, n_tmo_plus;

    logic                accept;
    logic [4:0]          words;
    logic [3:0]          words_m1;
    logic [6:0]          mul_k;
    logic [14:0]         tmo_num;
    logic [30:0]         div_prod;
    logic [11:0]         div_q;
    logic [7:0]          cmd_rd;
    logic [7:0]          cmd_wr;
    logic [6:0]          addr;
    logic [7:0]          sum_wr;
    logic [7:0]          chk_wr;
    logic [7:0]          sum_rd;

    assign o_in_ready = !i_full && !r_tmo_pend;
    assign accept     = i_in_valid && o_in_ready;

    assign div_prod = 31'(r_tmo_num) * 31'(mcuce_pkg::DIV10_MUL);
    assign div_q    = 12'(div_prod >> mcuce_pkg::DIV10_SHIFT);

    always_comb begin
        if (i_word_count == 5'd0) begin
            words = 5'd1;
        end else if (i_word_count > 5'(mcuce_pkg::MAX_WORDS)) begin
            words = 5'(mcuce_pkg::MAX_WORDS);
        end else begin
            words = i_word_count;
        end
        words_m1 = 4'(words - 5'd1);
        addr     = i_reg_addr & mcuce_pkg::ADDR_MASK;
        cmd_rd   = {words_m1, r_slave_addr, mcuce_pkg::CODE_READ};
        cmd_wr   = {4'd0, r_slave_addr,
                    (i_func == mcuce_pkg::FUNC_WRITE) ? mcuce_pkg::CODE_WRITE
                                                      : mcuce_pkg::CODE_BROADCAST};
        sum_rd   = cmd_rd + {1'b0, addr};
        sum_wr   = cmd_wr + {1'b0, addr} + i_write_data[7:0] + i_write_data[15:8]
                   + i_write_data[23:16] + i_write_data[31:24];
        chk_wr   = mcuce_pkg::fin_sum(sum_wr);
        case (i_func)
            mcuce_pkg::FUNC_READ: begin
                mul_k = {words, 2'b00} + 7'd5;
            end
            mcuce_pkg::FUNC_WRITE: begin
                mul_k = mcuce_pkg::MUL_WRITE;
            end
            default: begin
                mul_k = mcuce_pkg::MUL_BCAST;
            end
        endcase
        tmo_num = 15'(r_byte_time) * 15'(mul_k) + mcuce_pkg::TMO_ROUND;
    end

    always_comb begin
        n_slave_addr   = r_slave_addr;
        n_byte_time    = r_byte_time;
        n_phase        = r_phase;
        n_pending_op   = r_pending_op;
        n_expect_sum   = r_expect_sum;
        n_rx_count     = r_rx_count;
        n_rx_total     = r_rx_total;
        n_word_shift   = r_word_shift;
        n_timeout_left = r_timeout_left;
        n_tmo_pend     = 1'b0;
        n_tmo_num      = r_tmo_num;
        n_tmo_plus     = r_tmo_plus;
        o_push         = 1'b0;
        o_desc         = '0;
        o_desc.cmd     = cmd_wr;
        o_desc.addr    = addr;
        o_desc.data    = i_write_data;
        o_desc.sum     = chk_wr;

        if (i_cfg_wr_en) begin
            case (i_cfg_index)
                mcuce_pkg::CFG_SLAVE_ADDR: n_slave_addr = i_cfg_wdata[1:0];
                mcuce_pkg::CFG_BYTE_TIME:  n_byte_time  = i_cfg_wdata;
                default: ;
            endcase
        end

        if (r_tmo_pend) begin
            n_timeout_left = 16'(div_q) + 16'(r_tmo_plus);
        end

        if (accept) begin
            case (i_func)
                mcuce_pkg::FUNC_WRITE, mcuce_pkg::FUNC_READ, mcuce_pkg::FUNC_BCAST: begin
                    o_push = 1'b1;
                    if (r_phase != mcuce_pkg::PH_IDLE) begin
                        o_desc.act    = mcuce_pkg::ACT_STATUS;
                        o_desc.status = mcuce_pkg::ST_BUSY;
                    end else begin
                        n_rx_count   = '0;
                        n_word_shift = '0;
                        n_tmo_pend   = 1'b1;
                        n_tmo_num    = tmo_num;
                        if (i_func == mcuce_pkg::FUNC_READ) begin
                            o_desc.act   = mcuce_pkg::ACT_FRAME4;
                            o_desc.cmd   = cmd_rd;
                            o_desc.sum   = mcuce_pkg::fin_sum(sum_rd);
                            n_phase      = mcuce_pkg::PH_RX;
                            n_pending_op = mcuce_pkg::OP_READ;
                            n_expect_sum = sum_rd;
                            n_rx_total   = {words, 2'b00} + 7'd1;
                            n_tmo_plus   = 1'b1;
                        end else if (i_func == mcuce_pkg::FUNC_WRITE) begin
                            o_desc.act   = mcuce_pkg::ACT_FRAME8;
                            n_phase      = mcuce_pkg::PH_RX;
                            n_pending_op = mcuce_pkg::OP_WRITE;
                            n_expect_sum = chk_wr;
                            n_rx_total   = 7'd1;
                            n_tmo_plus   = 1'b1;
                        end else begin
                            o_desc.act   = mcuce_pkg::ACT_FRAME8;
                            n_phase      = mcuce_pkg::PH_BCAST;
                            n_pending_op = mcuce_pkg::OP_BCAST;
                            n_rx_total   = '0;
                            n_tmo_plus   = 1'b0;
                        end
                    end
                end
                mcuce_pkg::FUNC_RX: begin
                    if (r_phase == mcuce_pkg::PH_RX) begin
                        if (r_pending_op == mcuce_pkg::OP_WRITE) begin
                            n_phase       = mcuce_pkg::PH_IDLE;
                            n_rx_count    = 7'd1;
                            o_push        = 1'b1;
                            o_desc.act    = mcuce_pkg::ACT_STATUS;
                            o_desc.status = (i_rx_byte == r_expect_sum) ?
                                            mcuce_pkg::ST_OK : mcuce_pkg::ST_BAD_SUM;
                        end else if (r_rx_count + 7'd1 < r_rx_total) begin
                            n_expect_sum = r_expect_sum + i_rx_byte;
                            n_rx_count   = r_rx_count + 7'd1;
                            case (r_rx_count[1:0])
                                2'd0: n_word_shift = r_word_shift | {16'd0, i_rx_byte};
                                2'd1: n_word_shift = r_word_shift | {8'd0, i_rx_byte, 8'd0};
                                2'd2: n_word_shift = r_word_shift | {i_rx_byte, 16'd0};
                                default: begin
                                    n_word_shift = '0;
                                    o_push       = 1'b1;
                                    o_desc.act   = mcuce_pkg::ACT_WORD;
                                    o_desc.data  = {i_rx_byte, r_word_shift};
                                end
                            endcase
                        end else begin
                            n_phase       = mcuce_pkg::PH_IDLE;
                            n_rx_count    = r_rx_count + 7'd1;
                            o_push        = 1'b1;
                            o_desc.act    = mcuce_pkg::ACT_STATUS;
                            o_desc.status = (i_rx_byte == mcuce_pkg::fin_sum(r_expect_sum)) ?
                                            mcuce_pkg::ST_OK : mcuce_pkg::ST_BAD_SUM;
                        end
                    end
                end
                mcuce_pkg::FUNC_TICK: begin
                    if (r_timeout_left != '0) begin
                        n_timeout_left = r_timeout_left - 16'd1;
                        if (r_timeout_left == 16'd1) begin
                            if (r_phase == mcuce_pkg::PH_RX) begin
                                n_phase       = mcuce_pkg::PH_IDLE;
                                o_push        = 1'b1;
                                o_desc.act    = mcuce_pkg::ACT_STATUS;
                                o_desc.status = mcuce_pkg::ST_TIMEOUT;
                            end else if (r_phase == mcuce_pkg::PH_BCAST) begin
                                n_phase       = mcuce_pkg::PH_IDLE;
                                o_push        = 1'b1;
                                o_desc.act    = mcuce_pkg::ACT_STATUS;
                                o_desc.status = mcuce_pkg::ST_OK;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_addr   <= '0;
            r_byte_time    <= 8'd1;
            r_phase        <= mcuce_pkg::PH_IDLE;
            r_pending_op   <= mcuce_pkg::OP_WRITE;
            r_expect_sum   <= '0;
            r_rx_count     <= '0;
            r_rx_total     <= '0;
            r_word_shift   <= '0;
            r_timeout_left <= '0;
            r_tmo_pend     <= 1'b0;
        end else begin
            r_slave_addr   <= n_slave_addr;
            r_byte_time    <= n_byte_time;
            r_phase        <= n_phase;
            r_pending_op   <= n_pending_op;
            r_expect_sum   <= n_expect_sum;
            r_rx_count     <= n_rx_count;
            r_rx_total     <= n_rx_total;
            r_word_shift   <= n_word_shift;
            r_timeout_left <= n_timeout_left;
            r_tmo_pend     <= n_tmo_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tmo_num  <= n_tmo_num;
        r_tmo_plus <= n_tmo_plus;
    end

endmodule

### sv/mcuce_back.sv
// Back of the engine: expands queued descriptors into result beats and
// holds each beat in the output register. Uses mcuce_pkg.
`timescale 1ns / 1ps

module mcuce_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mcuce_pkg::t_desc  i_desc,
    input  logic              i_desc_valid,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_kind,
    output logic [7:0]        o_tx_byte,
    output logic [31:0]       o_read_word,
    output logic [1:0]        o_status,
    output logic              o_last
);

    mcuce_pkg::t_desc r_cur;
    logic             r_busy, n_busy;
    logic [2:0]       r_idx, n_idx;
    logic             r_ovalid, n_ovalid;
    logic [1:0]       r_kind;
    logic [7:0]       r_tx_byte;
    logic [31:0]      r_read_word;
    logic [1:0]       r_status;
    logic             r_last;

    logic             slot_free;
    logic             emit;
    logic             beat_last;
    logic [2:0]       last_idx;
    logic [1:0]       b_kind;
    logic [7:0]       b_tx;
    logic [31:0]      b_word;
    logic [1:0]       b_status;

    assign slot_free = !r_ovalid || i_out_ready;
    assign emit      = r_busy && slot_free;
    assign beat_last = (r_idx == last_idx);
    assign o_pop     = i_desc_valid && (!r_busy || (emit && beat_last));

    always_comb begin
        last_idx = 3'd0;
        b_kind   = mcuce_pkg::KIND_TX;
        b_tx     = '0;
        b_word   = '0;
        b_status = mcuce_pkg::ST_OK;
        case (r_cur.act)
            mcuce_pkg::ACT_FRAME4, mcuce_pkg::ACT_FRAME8: begin
                last_idx = (r_cur.act == mcuce_pkg::ACT_FRAME4) ? 3'd3 : 3'd7;
                case (r_idx)
                    3'd0: b_tx = mcuce_pkg::FRAME_START;
                    3'd1: b_tx = r_cur.cmd;
                    3'd2: b_tx = {1'b0, r_cur.addr};
                    3'd3: b_tx = (r_cur.act == mcuce_pkg::ACT_FRAME4) ?
                                 r_cur.sum : r_cur.data[7:0];
                    3'd4: b_tx = r_cur.data[15:8];
                    3'd5: b_tx = r_cur.data[23:16];
                    3'd6: b_tx = r_cur.data[31:24];
                    default: b_tx = r_cur.sum;
                endcase
            end
            mcuce_pkg::ACT_WORD: begin
                b_kind = mcuce_pkg::KIND_WORD;
                b_word = r_cur.data;
            end
            default: begin
                b_kind   = mcuce_pkg::KIND_STATUS;
                b_status = r_cur.status;
            end
        endcase

        n_busy = r_busy;
        n_idx  = r_idx;
        if (o_pop) begin
            n_busy = 1'b1;
            n_idx  = '0;
        end else if (emit) begin
            n_busy = !beat_last;
            n_idx  = r_idx + 3'd1;
        end

        if (emit) begin
            n_ovalid = 1'b1;
        end else if (i_out_ready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_idx    <= n_idx;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_desc;
        end
        if (emit) begin
            r_kind      <= b_kind;
            r_tx_byte   <= b_tx;
            r_read_word <= b_word;
            r_status    <= b_status;
            r_last      <= beat_last;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_kind      = r_kind;
    assign o_tx_byte   = r_tx_byte;
    assign o_read_word = r_read_word;
    assign o_status    = r_status;
    assign o_last      = r_last;

endmodule

### sv/meter_chip_uart_command_engine_unit.sv
// Results pass the descriptor queue, then the back end's descriptor and output registers.
// Throughput: one beat per cycle out unless i_out_ready stalls it; a request frame is 4 or 8 bytes.
// The front takes one item per cycle, except the cycle after an idle-state request (timeout divide),
// and stalls only when the descriptor queue is full.
// Reset (synchronous, active low) returns to idle with an empty queue; no clearing pass.
`timescale 1ns / 1ps

module meter_chip_uart_command_engine_unit #(
    parameter int QUEUE_DEPTH = mcuce_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_func,
    input  logic [6:0]  i_reg_addr,
    input  logic [31:0] i_write_data,
    input  logic [4:0]  i_word_count,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_tx_byte,
    output logic [31:0] o_read_word,
    output logic [1:0]  o_status,
    output logic        o_last
);

    logic             push;
    logic             pop;
    logic             full;
    logic             empty;
    mcuce_pkg::t_desc push_desc;
    mcuce_pkg::t_desc head_desc;

    mcuce_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_func       (i_func),
        .i_reg_addr   (i_reg_addr),
        .i_write_data (i_write_data),
        .i_word_count (i_word_count),
        .i_rx_byte    (i_rx_byte),
        .o_push       (push),
        .o_desc       (push_desc),
        .i_full       (full)
    );

    mcuce_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_desc),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (head_desc),
        .o_empty (empty)
    );

    mcuce_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc       (head_desc),
        .i_desc_valid (!empty),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_kind       (o_kind),
        .o_tx_byte    (o_tx_byte),
        .o_read_word  (o_read_word),
        .o_status     (o_status),
        .o_last       (o_last)
    );

endmodule

### sv/mcuce_checker.sv
// Port-level checker for the UART command engine, bound to the top level.
// Depends on mcuce_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "meter_chip_uart_command_engine_unit_macros.svh"

module mcuce_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_kind,
    input logic [7:0]  o_tx_byte,
    input logic [31:0] o_read_word,
    input logic [1:0]  o_status,
    input logic        o_last
);

    // A stalled beat keeps its payload.
    `MCUCE_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind) && $stable(o_tx_byte) && $stable(o_read_word) && $stable(o_last), "stalled beat changed")

    // Frame bytes leave without gaps until the closing checksum byte.
    `MCUCE_ASSERT(a_frame_gapless, o_out_valid && i_out_ready && o_kind == mcuce_pkg::KIND_TX && !o_last |=> o_out_valid && o_kind == mcuce_pkg::KIND_TX, "gap inside a frame")

    // Word and status results are always single beats.
    `MCUCE_ASSERT(a_single_last, o_out_valid && o_kind != mcuce_pkg::KIND_TX |-> o_last, "multi-beat word or status")

    // Frame bytes carry no word or status content.
    `MCUCE_ASSERT(a_tx_clean, o_out_valid && o_kind == mcuce_pkg::KIND_TX |-> o_read_word == '0 && o_status == mcuce_pkg::ST_OK, "frame byte with stray fields")

    // Status beats carry no byte or word content.
    `MCUCE_ASSERT(a_status_clean, o_out_valid && o_kind == mcuce_pkg::KIND_STATUS |-> o_read_word == '0 && o_tx_byte == '0, "status beat with stray fields")

endmodule

bind meter_chip_uart_command_engine_unit mcuce_checker u_mcuce_checker (.*);
